>>> src/ssos_pkg.sv
// Shared types, constants and encodings for the sonar servo opening scanner.
package ssos_pkg;

    // Angles in degrees
    localparam int          ANGLE_W     = 8;
    localparam logic [7:0]  DEG_CENTER  = 8'd90;
    localparam logic [7:0]  DEG_MAX     = 8'd180;
    localparam logic [7:0]  DEG_MIN     = 8'd0;

    // Echo parameter default and range limit for an echo of zero
    localparam int ECHO_BITS_DEF = 16;
    localparam int MAX_RANGE_CM  = 400;
    localparam int RANGE_W       = 10;

    // Distance judgement: echo*343 is compared against cm*20000
    localparam int ECHO_SCALE   = 343;
    localparam int ECHO_SCALE_W = 9;
    localparam int CM_SCALE     = 20000;
    localparam int CM_SCALE_W   = 15;
    localparam int CM_W         = 9;

    // Pulse mapping: divide by 180 through a reciprocal multiply
    localparam int PULSE_W   = 12;
    localparam int PROD_W    = ANGLE_W + PULSE_W;
    localparam int RECIP_SH  = 27;
    localparam int RECIP_W   = 20;
    localparam logic [RECIP_W-1:0] RECIP_180 = RECIP_W'((1 << RECIP_SH) / 180);
    localparam logic [PROD_W-1:0]  DIVISOR   = PROD_W'(180);

    // Streak counter
    localparam int          STREAK_W   = 4;
    localparam logic [3:0]  STREAK_MAX = 4'hF;

    // Scan phase, one-hot
    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_CENTER   = 7'b0000010,
        PH_LEFT     = 7'b0000100,
        PH_RIGHT    = 7'b0001000,
        PH_RECENTER = 7'b0010000,
        PH_FOUND    = 7'b0100000,
        PH_BLOCKED  = 7'b1000000
    } t_phase;

    // Phase codes as reported on the result channel
    localparam logic [2:0] CODE_IDLE     = 3'd0;
    localparam logic [2:0] CODE_CENTER   = 3'd1;
    localparam logic [2:0] CODE_LEFT     = 3'd2;
    localparam logic [2:0] CODE_RIGHT    = 3'd3;
    localparam logic [2:0] CODE_RECENTER = 3'd4;
    localparam logic [2:0] CODE_FOUND    = 3'd5;
    localparam logic [2:0] CODE_BLOCKED  = 3'd6;

    // Action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_SLEW_STEP  = 3'd0,
        CFG_CHECK_STEP = 3'd1,
        CFG_CONFIRM    = 3'd2,
        CFG_CLEAR_CM   = 3'd3,
        CFG_MIN_RANGE  = 3'd4,
        CFG_PULSE_MIN  = 3'd5,
        CFG_PULSE_MAX  = 3'd6,
        CFG_LEFT_LOW   = 3'd7
    } t_cfg_idx;

    localparam int CFG_DATA_W = 12;

    // Distance thresholds handed to the ping judges
    typedef struct packed {
        logic [CM_W-1:0] clear_cm;
        logic [CM_W-1:0] min_range_cm;
    } t_ping_cfg;

endpackage

>>> src/ssos_ping.sv
// Judges one sonar echo time as clear or blocked against the distance thresholds.
module ssos_ping #(
    parameter int ECHO_BITS = ssos_pkg::ECHO_BITS_DEF
) (
    input  logic [ECHO_BITS-1:0] i_echo_us,
    input  ssos_pkg::t_ping_cfg  i_cfg,
    output logic                 o_clear
);

    localparam int SC_W  = ECHO_BITS + ssos_pkg::ECHO_SCALE_W;
    localparam int LIM_W = ssos_pkg::CM_W + ssos_pkg::CM_SCALE_W;
    localparam int CMP_W = (SC_W > LIM_W) ? SC_W : LIM_W;

    logic [CMP_W-1:0] scaled;
    logic [CMP_W-1:0] clear_lim;
    logic [CMP_W-1:0] min_lim;
    logic             zero_clear;

    // Scale echo and thresholds to a common unit (constant multipliers)
    assign scaled    = CMP_W'(i_echo_us) * CMP_W'(ssos_pkg::ECHO_SCALE);
    assign clear_lim = CMP_W'(i_cfg.clear_cm) * CMP_W'(ssos_pkg::CM_SCALE);
    assign min_lim   = CMP_W'(i_cfg.min_range_cm) * CMP_W'(ssos_pkg::CM_SCALE);

    // No echo reads as the maximum range
    assign zero_clear = ssos_pkg::RANGE_W'(ssos_pkg::MAX_RANGE_CM)
                        >= ssos_pkg::RANGE_W'(i_cfg.clear_cm);

    // Below the minimum range the distance counts as zero
    always_comb begin
        if (i_echo_us == '0) begin
            o_clear = zero_clear;
        end else if (scaled < min_lim) begin
            o_clear = (i_cfg.clear_cm == '0);
        end else begin
            o_clear = (scaled >= clear_lim);
        end
    end

endmodule

>>> src/sonar_servo_opening_scanner.sv
// Top level of the servo-swept sonar opening scanner: scan sequencer and pulse pipeline.
//
//  Channel  | Signals                                     | Dir | Beat
//  ---------+---------------------------------------------+-----+---------------------------
//  in       | i_valid, o_stall, i_action, i_echo_*_us     | in  | one start or slew tick
//  out      | o_valid, i_stall, o_servo_angle, o_pulse_us,| out | one result per input beat
//           | o_phase, o_check_made, o_check_clear,       |     |
//           | o_relative_deg                              |     |
//  cfg      | i_cfg_valid, o_cfg_ready, i_cfg_index,      | in  | one register write
//           | i_cfg_data                                  |     |
//
// An input beat can be taken every cycle while o_stall is low; the scan state updates
// at the accepting edge. Each result passes through registered stages a, b and c into the
// output registers: the pulse width runs through a multiply stage, a reciprocal multiply
// for the divide by 180 and a correction stage.
// Synchronous active-low reset returns the scan to idle at 90 degrees and loads the
// register defaults; no clearing pass is needed. A stall on the output holds the last
// stage and backs up the pipeline; o_stall rises only when all four stages are full.
module sonar_servo_opening_scanner #(
    parameter int ECHO_BITS = ssos_pkg::ECHO_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_action,
    input  logic [ECHO_BITS-1:0]  i_echo_first_us,
    input  logic [ECHO_BITS-1:0]  i_echo_second_us,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_servo_angle,
    output logic [11:0]           o_pulse_us,
    output logic [2:0]            o_phase,
    output logic                  o_check_made,
    output logic                  o_check_clear,
    output logic signed [7:0]     o_relative_deg,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [ssos_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = ssos_pkg::ANGLE_W;
    localparam int PW = ssos_pkg::PULSE_W;
    localparam int XW = ssos_pkg::PROD_W;
    localparam int MW = ssos_pkg::PROD_W + ssos_pkg::RECIP_W;

    // Move one slew step toward a target, clamped at the target
    function automatic logic [AW-1:0] f_move(input logic [AW-1:0] a,
                                             input logic [AW-1:0] t,
                                             input logic [AW-1:0] step);
        logic [AW-1:0] res;
        res = a;
        if (a < t) begin
            res = (step >= t - a) ? t : a + step;
        end else if (a > t) begin
            res = (step >= a - t) ? t : a - step;
        end
        return res;
    endfunction

    // Map a one-hot phase to its reported code
    function automatic logic [2:0] f_code(input ssos_pkg::t_phase ph);
        logic [2:0] c;
        case (ph)
            ssos_pkg::PH_IDLE:     c = ssos_pkg::CODE_IDLE;
            ssos_pkg::PH_CENTER:   c = ssos_pkg::CODE_CENTER;
            ssos_pkg::PH_LEFT:     c = ssos_pkg::CODE_LEFT;
            ssos_pkg::PH_RIGHT:    c = ssos_pkg::CODE_RIGHT;
            ssos_pkg::PH_RECENTER: c = ssos_pkg::CODE_RECENTER;
            ssos_pkg::PH_FOUND:    c = ssos_pkg::CODE_FOUND;
            ssos_pkg::PH_BLOCKED:  c = ssos_pkg::CODE_BLOCKED;
            default:               c = ssos_pkg::CODE_IDLE;
        endcase
        return c;
    endfunction

    // Configuration registers
    logic [7:0]    r_slew_step;
    logic [7:0]    r_check_step;
    logic [3:0]    r_confirm;
    logic [8:0]    r_clear_cm;
    logic [8:0]    r_min_range;
    logic [PW-1:0] r_pulse_min;
    logic [PW-1:0] r_pulse_max;
    logic          r_left_low;

    // Scan state
    logic [AW-1:0]             r_angle,  n_angle;
    ssos_pkg::t_phase          r_phase,  n_phase;
    logic [AW-1:0]             r_last,   n_last;
    logic [ssos_pkg::STREAK_W-1:0] r_streak, n_streak;
    logic [AW-1:0]             r_stop,   n_stop;
    logic                      r_found,  n_found;

    // Pipeline stages
    logic                 r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic [AW-1:0]        r_a_angle, r_b_angle, r_c_angle;
    logic [2:0]           r_a_phase, r_b_phase, r_c_phase;
    logic                 r_a_made,  r_b_made,  r_c_made;
    logic                 r_a_clear, r_b_clear, r_c_clear;
    logic [7:0]           r_a_rel,   r_b_rel,   r_c_rel;
    logic [XW-1:0]        r_b_mag,   r_c_mag;
    logic                 r_b_neg,   r_c_neg;
    logic [PW-1:0]        r_c_q0;

    logic                 in_acc;
    logic                 a_ready, b_ready, c_ready, d_ready;
    logic                 made, clr, ping_a, ping_b;
    logic [AW-1:0]        step, glide_tgt, moved_c, moved_g, travel;
    logic [ssos_pkg::STREAK_W-1:0] streak_inc, streak_chk;
    logic [7:0]           rel_next;
    logic [PW-1:0]        span_mag;
    logic                 span_neg;
    logic [MW-1:0]        recip_prod;
    logic [XW-1:0]        q0_times, rem;
    logic [PW-1:0]        q_fix, pulse_next;
    ssos_pkg::t_ping_cfg  ping_cfg;

    // Handshakes: each stage advances when the next one has room
    assign d_ready     = !r_d_valid || !i_stall;
    assign c_ready     = !r_c_valid || d_ready;
    assign b_ready     = !r_b_valid || c_ready;
    assign a_ready     = !r_a_valid || b_ready;
    assign o_stall     = !a_ready;
    assign in_acc      = i_valid && a_ready;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_d_valid;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slew_step  <= 8'd1;
            r_check_step <= 8'd10;
            r_confirm    <= 4'd3;
            r_clear_cm   <= 9'd100;
            r_min_range  <= 9'd2;
            r_pulse_min  <= 12'd500;
            r_pulse_max  <= 12'd2500;
            r_left_low   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ssos_pkg::t_cfg_idx'(i_cfg_index))
                ssos_pkg::CFG_SLEW_STEP:  r_slew_step  <= i_cfg_data[7:0];
                ssos_pkg::CFG_CHECK_STEP: r_check_step <= i_cfg_data[7:0];
                ssos_pkg::CFG_CONFIRM:    r_confirm    <= i_cfg_data[3:0];
                ssos_pkg::CFG_CLEAR_CM:   r_clear_cm   <= i_cfg_data[8:0];
                ssos_pkg::CFG_MIN_RANGE:  r_min_range  <= i_cfg_data[8:0];
                ssos_pkg::CFG_PULSE_MIN:  r_pulse_min  <= i_cfg_data[PW-1:0];
                ssos_pkg::CFG_PULSE_MAX:  r_pulse_max  <= i_cfg_data[PW-1:0];
                ssos_pkg::CFG_LEFT_LOW:   r_left_low   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Judge both pings
    assign ping_cfg.clear_cm     = r_clear_cm;
    assign ping_cfg.min_range_cm = r_min_range;

    ssos_ping #(.ECHO_BITS(ECHO_BITS)) u_ping_first (
        .i_echo_us (i_echo_first_us),
        .i_cfg     (ping_cfg),
        .o_clear   (ping_a)
    );

    ssos_ping #(.ECHO_BITS(ECHO_BITS)) u_ping_second (
        .i_echo_us (i_echo_second_us),
        .i_cfg     (ping_cfg),
        .o_clear   (ping_b)
    );

    // Movement candidates and check distance
    assign step       = (r_slew_step == '0) ? AW'(1) : r_slew_step;
    assign glide_tgt  = ((r_phase == ssos_pkg::PH_LEFT) != r_left_low) ?
                        ssos_pkg::DEG_MAX : ssos_pkg::DEG_MIN;
    assign moved_c    = f_move(r_angle, ssos_pkg::DEG_CENTER, step);
    assign moved_g    = f_move(r_angle, glide_tgt, step);
    assign travel     = (moved_g >= r_last) ? moved_g - r_last : r_last - moved_g;
    assign streak_inc = (r_streak == ssos_pkg::STREAK_MAX) ? r_streak : r_streak + 1'b1;

    // Scan sequencer next state
    always_comb begin
        n_angle    = r_angle;
        n_phase    = r_phase;
        n_last     = r_last;
        n_streak   = r_streak;
        n_stop     = r_stop;
        n_found    = r_found;
        made       = 1'b0;
        clr        = 1'b0;
        streak_chk = '0;
        if (i_action == ssos_pkg::ACT_START) begin
            // start only from a finished or idle scan
            if (r_phase == ssos_pkg::PH_IDLE || r_phase == ssos_pkg::PH_FOUND ||
                r_phase == ssos_pkg::PH_BLOCKED) begin
                n_found  = 1'b0;
                n_stop   = ssos_pkg::DEG_CENTER;
                n_streak = '0;
                n_last   = ssos_pkg::DEG_CENTER;
                n_phase  = (r_angle == ssos_pkg::DEG_CENTER) ?
                           ssos_pkg::PH_LEFT : ssos_pkg::PH_CENTER;
            end
        end else begin
            case (r_phase)
                ssos_pkg::PH_CENTER: begin
                    n_angle = moved_c;
                    if (moved_c == ssos_pkg::DEG_CENTER) begin
                        n_phase  = ssos_pkg::PH_LEFT;
                        n_last   = moved_c;
                        n_streak = '0;
                    end
                end
                ssos_pkg::PH_LEFT, ssos_pkg::PH_RIGHT: begin
                    if (r_angle == glide_tgt) begin
                        // glide already at its limit: end it without a move
                        if (r_phase == ssos_pkg::PH_LEFT) begin
                            n_phase  = ssos_pkg::PH_RIGHT;
                            n_last   = r_angle;
                            n_streak = '0;
                        end else begin
                            n_stop  = glide_tgt;
                            n_found = 1'b0;
                            n_phase = (r_angle == ssos_pkg::DEG_CENTER) ?
                                      ssos_pkg::PH_BLOCKED : ssos_pkg::PH_RECENTER;
                        end
                    end else begin
                        n_angle = moved_g;
                        if (travel >= r_check_step || moved_g == glide_tgt) begin
                            // check point: judge the pings and update the streak
                            n_last     = moved_g;
                            made       = 1'b1;
                            clr        = ping_a && ping_b;
                            streak_chk = clr ? streak_inc : '0;
                            n_streak   = streak_chk;
                            if (streak_chk >= r_confirm) begin
                                n_stop  = moved_g;
                                n_found = 1'b1;
                                n_phase = (moved_g == ssos_pkg::DEG_CENTER) ?
                                          ssos_pkg::PH_FOUND : ssos_pkg::PH_RECENTER;
                            end else if (moved_g == glide_tgt) begin
                                if (r_phase == ssos_pkg::PH_LEFT) begin
                                    n_phase  = ssos_pkg::PH_RIGHT;
                                    n_streak = '0;
                                end else begin
                                    n_stop  = glide_tgt;
                                    n_found = 1'b0;
                                    n_phase = (moved_g == ssos_pkg::DEG_CENTER) ?
                                              ssos_pkg::PH_BLOCKED :
                                              ssos_pkg::PH_RECENTER;
                                end
                            end
                        end
                    end
                end
                ssos_pkg::PH_RECENTER: begin
                    n_angle = moved_c;
                    if (moved_c == ssos_pkg::DEG_CENTER) begin
                        n_phase = r_found ? ssos_pkg::PH_FOUND : ssos_pkg::PH_BLOCKED;
                    end
                end
                default: ;
            endcase
        end
    end

    // Relative opening angle, signed by scan direction
    always_comb begin
        if (!n_found) begin
            rel_next = '0;
        end else if (r_left_low) begin
            rel_next = ssos_pkg::DEG_CENTER - n_stop;
        end else begin
            rel_next = n_stop - ssos_pkg::DEG_CENTER;
        end
    end

    // Update the scan state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle  <= ssos_pkg::DEG_CENTER;
            r_phase  <= ssos_pkg::PH_IDLE;
            r_last   <= ssos_pkg::DEG_CENTER;
            r_streak <= '0;
            r_stop   <= ssos_pkg::DEG_CENTER;
            r_found  <= 1'b0;
        end else if (in_acc) begin
            r_angle  <= n_angle;
            r_phase  <= n_phase;
            r_last   <= n_last;
            r_streak <= n_streak;
            r_stop   <= n_stop;
            r_found  <= n_found;
        end
    end

    // Pulse arithmetic for each stage
    assign span_neg   = r_pulse_max < r_pulse_min;
    assign span_mag   = span_neg ? r_pulse_min - r_pulse_max : r_pulse_max - r_pulse_min;
    assign recip_prod = MW'(r_b_mag) * MW'(ssos_pkg::RECIP_180);
    assign q0_times   = (XW'(r_c_q0) << 7) + (XW'(r_c_q0) << 5) +
                        (XW'(r_c_q0) << 4) + (XW'(r_c_q0) << 2);
    assign rem        = r_c_mag - q0_times;
    assign q_fix      = (rem >= ssos_pkg::DIVISOR) ? r_c_q0 + 1'b1 : r_c_q0;
    assign pulse_next = r_c_neg ? r_pulse_min - q_fix : r_pulse_min + q_fix;

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (a_ready) r_a_valid <= in_acc;
            if (b_ready) r_b_valid <= r_a_valid;
            if (c_ready) r_c_valid <= r_b_valid;
            if (d_ready) r_d_valid <= r_c_valid;
        end
    end

    // Pipeline payload: result fields ride along with the pulse math
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_angle <= n_angle;
            r_a_phase <= f_code(n_phase);
            r_a_made  <= made;
            r_a_clear <= clr;
            r_a_rel   <= rel_next;
        end
        if (b_ready && r_a_valid) begin
            r_b_angle <= r_a_angle;
            r_b_phase <= r_a_phase;
            r_b_made  <= r_a_made;
            r_b_clear <= r_a_clear;
            r_b_rel   <= r_a_rel;
            r_b_mag   <= XW'(r_a_angle) * XW'(span_mag);
            r_b_neg   <= span_neg;
        end
        if (c_ready && r_b_valid) begin
            r_c_angle <= r_b_angle;
            r_c_phase <= r_b_phase;
            r_c_made  <= r_b_made;
            r_c_clear <= r_b_clear;
            r_c_rel   <= r_b_rel;
            r_c_mag   <= r_b_mag;
            r_c_neg   <= r_b_neg;
            r_c_q0    <= recip_prod[ssos_pkg::RECIP_SH +: PW];
        end
        if (d_ready && r_c_valid) begin
            o_servo_angle  <= r_c_angle;
            o_pulse_us     <= pulse_next;
            o_phase        <= r_c_phase;
            o_check_made   <= r_c_made;
            o_check_clear  <= r_c_clear;
            o_relative_deg <= r_c_rel;
        end
    end

`ifndef ASSERT_OFF
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_servo_angle <= ssos_pkg::DEG_MAX)
        else $error("servo angle beyond 180");

    a_clear_needs_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_check_clear |-> o_check_made)
        else $error("clear reported without a check");

    a_found_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ssos_pkg::PH_FOUND) |-> r_found)
        else $error("found phase without an opening");

    a_blocked_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ssos_pkg::PH_BLOCKED || r_phase == ssos_pkg::PH_IDLE) |-> !r_found)
        else $error("opening flagged in idle or blocked phase");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_a_valid)
        else $error("accepted beat missing from first stage");
`endif

endmodule

>>> test/ssos_result_checker.sv
// Scoreboard for the sonar servo opening scanner: mirrors the scan state and checks each result.
module ssos_result_checker
    import ssos_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_action,
    input  logic [15:0]           i_echo_first_us,
    input  logic [15:0]           i_echo_second_us,
    // result channel
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [7:0]            i_servo_angle,
    input  logic [11:0]           i_pulse_us,
    input  logic [2:0]            i_phase,
    input  logic                  i_check_made,
    input  logic                  i_check_clear,
    input  logic [7:0]            i_relative_deg,
    // configuration channel
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // status toward the bench top
    output int                    o_waiting,
    output int                    o_mismatches
);

    typedef struct packed {
        logic [7:0]  angle;
        logic [11:0] pulse;
        logic [2:0]  phase;
        logic        made;
        logic        clear;
        logic [7:0]  rel;
    } t_servo_beat;

    // Register shadow
    logic [7:0]  slew_r;
    logic [7:0]  check_r;
    logic [3:0]  confirm_r;
    logic [8:0]  clear_r;
    logic [8:0]  minr_r;
    logic [11:0] pmin_r;
    logic [11:0] pmax_r;
    logic        left_low_r;

    // Scan state shadow
    logic [7:0]  angle_q;
    logic [7:0]  mark_q;
    logic [7:0]  stop_q;
    logic [2:0]  phase_q;
    logic [3:0]  streak_q;
    logic        found_q;

    t_servo_beat pending_q[$];
    int          mismatches = 0;

    // Load register defaults and the idle scan state
    function automatic void restore_defaults();
        slew_r     = 8'd1;
        check_r    = 8'd10;
        confirm_r  = 4'd3;
        clear_r    = 9'd100;
        minr_r     = 9'd2;
        pmin_r     = 12'd500;
        pmax_r     = 12'd2500;
        left_low_r = 1'b0;
        angle_q    = DEG_CENTER;
        mark_q     = DEG_CENTER;
        stop_q     = DEG_CENTER;
        phase_q    = CODE_IDLE;
        streak_q   = '0;
        found_q    = 1'b0;
    endfunction

    function automatic void store_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (t_cfg_idx'(idx))
            CFG_SLEW_STEP:  slew_r     = data[7:0];
            CFG_CHECK_STEP: check_r    = data[7:0];
            CFG_CONFIRM:    confirm_r  = data[3:0];
            CFG_CLEAR_CM:   clear_r    = data[8:0];
            CFG_MIN_RANGE:  minr_r     = data[8:0];
            CFG_PULSE_MIN:  pmin_r     = data[11:0];
            CFG_PULSE_MAX:  pmax_r     = data[11:0];
            CFG_LEFT_LOW:   left_low_r = data[0];
            default: ;
        endcase
    endfunction

    // Move one step toward the target, never past it; a zero step moves by one
    function automatic void slew_toward(input int target);
        int step;
        int a;
        step = (slew_r == 0) ? 1 : int'(slew_r);
        a = int'(angle_q);
        if (a < target) begin
            a = a + step;
            if (a > target) a = target;
        end else if (a > target) begin
            a = a - step;
            if (a < target) a = target;
        end
        angle_q = a[7:0];
    endfunction

    // Clear when the distance reaches clear_cm; no echo means full range,
    // anything closer than min_range_cm reads as zero distance
    function automatic bit echo_is_clear(input logic [15:0] echo);
        longint scaled;
        if (echo == '0) return MAX_RANGE_CM >= int'(clear_r);
        scaled = longint'(echo) * ECHO_SCALE;
        if (scaled < longint'(minr_r) * CM_SCALE) return clear_r == '0;
        return scaled >= longint'(clear_r) * CM_SCALE;
    endfunction

    function automatic void begin_recenter();
        phase_q = CODE_RECENTER;
        if (angle_q == DEG_CENTER) phase_q = found_q ? CODE_FOUND : CODE_BLOCKED;
    endfunction

    function automatic void begin_glide(input logic [2:0] ph);
        phase_q  = ph;
        mark_q   = angle_q;
        streak_q = '0;
    endfunction

    function automatic int glide_limit();
        bit to_left;
        to_left = (phase_q == CODE_LEFT);
        if (left_to_low()) return to_left ? 0 : 180;
        return to_left ? 180 : 0;
    endfunction

    function automatic bit left_to_low();
        return left_low_r;
    endfunction

    // Left glide hands over to the right one; the right one ends the scan blocked
    function automatic void finish_glide(input int target);
        if (phase_q == CODE_LEFT) begin
            begin_glide(CODE_RIGHT);
        end else begin
            stop_q  = target[7:0];
            found_q = 1'b0;
            begin_recenter();
        end
    endfunction

    // Apply one input beat to the shadow state and form the result it gives
    function automatic t_servo_beat advance_scan(input logic act, input logic [15:0] e1,
                                                 input logic [15:0] e2);
        t_servo_beat res;
        int target;
        int travel;
        int span;
        int pulse_i;
        int rel_i;
        res = '0;
        if (act == ACT_START) begin
            // restart only from a finished or idle scan
            if (phase_q == CODE_IDLE || phase_q == CODE_FOUND || phase_q == CODE_BLOCKED) begin
                found_q  = 1'b0;
                stop_q   = DEG_CENTER;
                streak_q = '0;
                mark_q   = DEG_CENTER;
                phase_q  = CODE_CENTER;
                if (angle_q == DEG_CENTER) begin_glide(CODE_LEFT);
            end
        end else if (phase_q == CODE_CENTER) begin
            slew_toward(90);
            if (angle_q == DEG_CENTER) begin_glide(CODE_LEFT);
        end else if (phase_q == CODE_LEFT || phase_q == CODE_RIGHT) begin
            target = glide_limit();
            if (int'(angle_q) == target) begin
                finish_glide(target);
            end else begin
                slew_toward(target);
                travel = int'(angle_q) - int'(mark_q);
                if (travel < 0) travel = -travel;
                if (travel >= int'(check_r) || int'(angle_q) == target) begin
                    mark_q    = angle_q;
                    res.made  = 1'b1;
                    res.clear = echo_is_clear(e1) && echo_is_clear(e2);
                    if (res.clear) begin
                        if (streak_q < STREAK_MAX) streak_q = streak_q + 4'd1;
                    end else begin
                        streak_q = '0;
                    end
                    if (streak_q >= confirm_r) begin
                        stop_q  = angle_q;
                        found_q = 1'b1;
                        begin_recenter();
                    end else if (int'(angle_q) == target) begin
                        finish_glide(target);
                    end
                end
            end
        end else if (phase_q == CODE_RECENTER) begin
            slew_toward(90);
            if (angle_q == DEG_CENTER) phase_q = found_q ? CODE_FOUND : CODE_BLOCKED;
        end

        // pulse width, quotient truncated toward zero even when the span is negative
        span    = int'(pmax_r) - int'(pmin_r);
        pulse_i = int'(pmin_r) + (int'(angle_q) * span) / int'(DEG_MAX);
        rel_i   = 0;
        if (found_q) begin
            rel_i = int'(stop_q) - 90;
            if (left_low_r) rel_i = -rel_i;
        end
        res.angle = angle_q;
        res.pulse = pulse_i[11:0];
        res.phase = phase_q;
        res.rel   = rel_i[7:0];
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t %s: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_servo_beat want;
        if (!i_rst_n) begin
            restore_defaults();
            pending_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) store_reg(i_cfg_index, i_cfg_data);

            // predict every accepted input beat
            if (i_in_valid && !i_in_stall)
                pending_q.push_back(advance_scan(i_action, i_echo_first_us, i_echo_second_us));

            // compare every accepted result beat with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                if (pending_q.size() == 0) begin
                    $display("%0t result beat with nothing expected: angle %0d phase %0d",
                             $time, i_servo_angle, i_phase);
                    mismatches++;
                end else begin
                    want = pending_q.pop_front();
                    check_field("servo_angle", int'(want.angle), int'(i_servo_angle));
                    check_field("pulse_us", int'(want.pulse), int'(i_pulse_us));
                    check_field("phase", int'(want.phase), int'(i_phase));
                    check_field("check_made", int'(want.made), int'(i_check_made));
                    check_field("check_clear", int'(want.clear), int'(i_check_clear));
                    check_field("relative_deg", int'($signed(want.rel)),
                                int'($signed(i_relative_deg)));
                end
            end
        end
        o_waiting    <= pending_q.size();
        o_mismatches <= mismatches;
    end

endmodule

>>> test/tb_top.sv
// Bench top for the sonar servo opening scanner: stimulus, handshake idling and the verdict.
module tb_top;
    import ssos_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 12;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_action = ACT_TICK;
    logic [15:0] echo_first = '0;
    logic [15:0] echo_second = '0;
    logic        res_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    t_cfg_idx    cfg_index = CFG_SLEW_STEP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_servo_angle;
    logic [11:0] o_pulse_us;
    logic [2:0]  o_phase;
    logic        o_check_made;
    logic        o_check_clear;
    logic signed [7:0] o_relative_deg;
    logic        o_cfg_ready;

    int          waiting;
    int          mismatches;
    int          idle_cycles = 0;

    // no-idle stretches for both sides
    bit          calm = 1'b0;
    // register copies used to aim the echo values and size the tick runs
    int          shape_slew = 1;
    int          shape_clear_cm = 100;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sonar_servo_opening_scanner uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (o_stall),
        .i_action         (in_action),
        .i_echo_first_us  (echo_first),
        .i_echo_second_us (echo_second),
        .o_valid          (o_valid),
        .i_stall          (res_stall),
        .o_servo_angle    (o_servo_angle),
        .o_pulse_us       (o_pulse_us),
        .o_phase          (o_phase),
        .o_check_made     (o_check_made),
        .o_check_clear    (o_check_clear),
        .o_relative_deg   (o_relative_deg),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    ssos_result_checker result_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (o_stall),
        .i_action         (in_action),
        .i_echo_first_us  (echo_first),
        .i_echo_second_us (echo_second),
        .i_out_valid      (o_valid),
        .i_out_stall      (res_stall),
        .i_servo_angle    (o_servo_angle),
        .i_pulse_us       (o_pulse_us),
        .i_phase          (o_phase),
        .i_check_made     (o_check_made),
        .i_check_clear    (o_check_clear),
        .i_relative_deg   (o_relative_deg),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_waiting        (waiting),
        .o_mismatches     (mismatches)
    );

    // Watchdog: end the run when no beat moves on any channel for too long
    always @(posedge clk) begin
        if ((in_valid && !o_stall) || (o_valid && !res_stall) || (cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before taking each beat
    initial begin : result_sink
        int hold;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (!o_valid) @(posedge clk);
        end
    end

    // Send one input beat after a random gap; valid stays high for a back-to-back beat
    task automatic put_item(input logic act, input logic [15:0] e1, input logic [15:0] e2);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_action   <= act;
        echo_first  <= e1;
        echo_second <= e2;
        @(posedge clk);
        while (o_stall) @(posedge clk);
    endtask

    // Drop valid and wait until every result is back and the pipeline is empty
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write the whole register set while the block is idle
    task automatic program_scan(input int slew, input int chk, input int confirm,
                                input int clear_cm, input int min_cm, input int pmin,
                                input int pmax, input int left_low);
        quiesce();
        cfg_write(CFG_SLEW_STEP, slew);
        cfg_write(CFG_CHECK_STEP, chk);
        cfg_write(CFG_CONFIRM, confirm);
        cfg_write(CFG_CLEAR_CM, clear_cm);
        cfg_write(CFG_MIN_RANGE, min_cm);
        cfg_write(CFG_PULSE_MIN, pmin);
        cfg_write(CFG_PULSE_MAX, pmax);
        cfg_write(CFG_LEFT_LOW, left_low);
        shape_slew     = (slew % 256 == 0) ? 1 : slew;
        shape_clear_cm = clear_cm;
    endtask

    // Echo time aimed at either side of the clear threshold, sometimes any pattern
    function automatic logic [15:0] scan_echo(input bit want_clear);
        int thr;
        int pick;
        thr = (shape_clear_cm * CM_SCALE + ECHO_SCALE - 1) / ECHO_SCALE;
        if (thr > 65535) thr = 65535;
        pick = $urandom_range(0, 7);
        if (pick == 0) return 16'($urandom_range(0, 65535));
        if (want_clear) begin
            if (pick == 1) return 16'd0;
            if (pick == 2) return thr[15:0];
            return 16'($urandom_range(thr, 65535));
        end
        if (thr <= 1) return 16'd1;
        if (pick == 1) return 16'(thr - 1);
        return 16'($urandom_range(1, thr - 1));
    endfunction

    // Whole scans with random echo content, plus a little noise
    task automatic sweep_scans(input int quota);
        int sent;
        int ticks;
        int clear_pct;
        int n;
        logic [15:0] e1;
        logic [15:0] e2;
        sent = 0;
        while (sent < quota) begin
            calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: clear_pct = 15;
                1: clear_pct = 50;
                default: clear_pct = 85;
            endcase
            put_item(ACT_START, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            sent++;
            ticks = 460 / shape_slew + 4;
            if (ticks > 150) ticks = 150;
            if ($urandom_range(0, 3) == 0) ticks = $urandom_range(1, ticks);
            for (n = 0; n < ticks && sent < quota; n++) begin
                if ($urandom_range(0, 19) == 0) begin
                    put_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)));
                end else begin
                    if ($urandom_range(0, 99) < clear_pct) begin
                        e1 = scan_echo(1'b1);
                        e2 = scan_echo(1'b1);
                    end else if ($urandom_range(0, 1) == 0) begin
                        e1 = scan_echo(1'b0);
                        e2 = 16'($urandom_range(0, 65535));
                    end else begin
                        e1 = scan_echo(1'b1);
                        e2 = scan_echo(1'b0);
                    end
                    put_item(ACT_TICK, e1, e2);
                end
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coarse steps: every check lands on a 45 degree mark
        program_scan(45, 45, 2, 100, 2, 500, 2500, 0);
        put_item(ACT_TICK, 16'd65535, 16'd0);       // tick while idle
        put_item(ACT_START, 16'd0, 16'd65535);      // already at center, straight to left
        put_item(ACT_START, 16'd65535, 16'd65535);  // start while scanning
        put_item(ACT_TICK, 16'd0, 16'd65535);       // no echo and farthest echo, both clear
        put_item(ACT_TICK, 16'd5831, 16'd5830);     // just at and just under the threshold
        put_item(ACT_TICK, 16'd116, 16'd65535);     // closer than the minimum range
        put_item(ACT_TICK, 16'd5831, 16'd0);
        put_item(ACT_TICK, 16'd65535, 16'd65535);   // second clear check confirms
        put_item(ACT_TICK, 16'd0, 16'd0);           // back at center, found
        put_item(ACT_TICK, 16'd0, 16'd0);           // tick while found
        put_item(ACT_START, 16'd0, 16'd0);
        put_item(ACT_TICK, 16'd1, 16'd1);
        put_item(ACT_TICK, 16'd5830, 16'd5830);
        put_item(ACT_TICK, 16'd117, 16'd65535);
        put_item(ACT_TICK, 16'd0, 16'd116);
        put_item(ACT_TICK, 16'd1, 16'd0);
        put_item(ACT_TICK, 16'd2, 16'd3);           // right limit, no opening
        put_item(ACT_TICK, 16'd0, 16'd0);
        put_item(ACT_TICK, 16'd0, 16'd0);           // recentered, blocked

        // Zero step, zero check step, zero confirm, swapped pulse limits, left at 0 deg
        program_scan(0, 0, 0, 0, 511, 4095, 0, 1);
        put_item(ACT_START, 16'd0, 16'd0);
        put_item(ACT_TICK, 16'd65535, 16'd65535);
        put_item(ACT_TICK, 16'd0, 16'd0);
        put_item(ACT_TICK, 16'd12345, 16'd54321);

        program_scan(9, 18, 3, 100, 2, 500, 2500, 0);
        sweep_scans(120);
        program_scan(255, 255, 15, 511, 0, 0, 4095, 1);
        sweep_scans(100);
        program_scan(1, 10, 1, 60, 2, 500, 2500, 1);
        sweep_scans(80);
        program_scan(180, 1, 1, 1, 400, 4095, 0, 0);
        sweep_scans(100);
        program_scan(17, 0, 2, 400, 0, 1234, 321, 1);
        sweep_scans(100);
        program_scan(6, 180, 0, 0, 511, 2500, 500, 0);
        sweep_scans(100);

        quiesce();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
